// File: rtl/two_point_sensor_calibration_core_assert.svh
// ----------------------------------------------------------------------------
// calibration core assertion macros
// implication helpers on clk_i with disable on rst_ni
// ----------------------------------------------------------------------------
`ifndef TWO_POINT_SENSOR_CALIBRATION_CORE_ASSERT_SVH
`define TWO_POINT_SENSOR_CALIBRATION_CORE_ASSERT_SVH

// same-cycle implication
`define TPSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tpsc_pkg.sv
// ----------------------------------------------------------------------------
// tpsc_pkg
// shared widths, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package tpsc_pkg;

  localparam int REF_T_W    = 10;
  localparam int REF_H_W    = 8;
  localparam int CNT_W      = 16;
  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_REGS   = 8;

  localparam int GAIN_FRAC_BITS_DEF  = 16;
  localparam int TEMP_REF_FRAC_BITS  = 3;
  localparam int HUM_REF_FRAC_BITS   = 1;

  localparam logic CH_TEMP = 1'b0;
  localparam logic CH_HUM  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_REF_LOW    = 4'd0,
    REG_TEMP_REF_HIGH   = 4'd1,
    REG_TEMP_COUNT_LOW  = 4'd2,
    REG_TEMP_COUNT_HIGH = 4'd3,
    REG_HUM_REF_LOW     = 4'd4,
    REG_HUM_REF_HIGH    = 4'd5,
    REG_HUM_COUNT_LOW   = 4'd6,
    REG_HUM_COUNT_HIGH  = 4'd7
  } tpsc_reg_e;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic gain_we;
    logic mul_bias;
    logic mul_we;
    logic bias_we;
    logic out_we;
    logic cal_ch;
  } tpsc_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic div_done;
  } tpsc_status_t;

endpackage

// File: rtl/two_point_sensor_calibration_core.sv
// ----------------------------------------------------------------------------
// two_point_sensor_calibration_core
// two-point linear calibration of temperature and humidity counts
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  in       sink       in_valid_i / in_stall_o  channel, report_processed, raw_sample
//  out      source     out_valid_o / out_stall_i channel_out, value, fraction_bits,
//                                              calib_error
//  cfg      sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// a sample with valid coefficients goes through accept, multiply and output write
// the first sample after reset or a register write first rederives both channels,
// temperature then humidity, each through the one-bit-per-cycle divider
// reset clears registers and coefficients; the first sample then recalibrates
// the result register lets the next sample in while a result waits; a stalled
// output only holds the block once the following result is ready to be written
//
module two_point_sensor_calibration_core import tpsc_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample transfer in
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  channel_i,
  input  logic                  report_processed_i,
  input  logic [CNT_W-1:0]      raw_sample_i,
  // result transfer out
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  channel_out_o,
  output logic [VAL_W-1:0]      value_o,
  output logic [FRAC_W-1:0]     fraction_bits_o,
  output logic                  calib_error_o,
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  `include "two_point_sensor_calibration_core_assert.svh"

  localparam logic [FRAC_W-1:0] FRAC_T = FRAC_W'(GAIN_FRACTION_BITS + TEMP_REF_FRAC_BITS);
  localparam logic [FRAC_W-1:0] FRAC_H = FRAC_W'(GAIN_FRACTION_BITS + HUM_REF_FRAC_BITS);

  tpsc_cmd_t    cmd_s;
  tpsc_status_t status_s;

  // sequencer: recalibration steps, conversion steps, output valid
  tpsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_s),
    .cmd_o       (cmd_s)
  );

  // registers, divider, shared multiplier and result register
  tpsc_datapath #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd_s),
    .status_o           (status_s),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .channel_i          (channel_i),
    .report_processed_i (report_processed_i),
    .raw_sample_i       (raw_sample_i),
    .channel_out_o      (channel_out_o),
    .value_o            (value_o),
    .fraction_bits_o    (fraction_bits_o),
    .calib_error_o      (calib_error_o)
  );

  // an accepted sample keeps the input closed while it is worked on
  `TPSC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accept not followed by busy")
  // divider only finishes inside a sample's recalibration
  `TPSC_ASSERT_IMP(a_div_while_busy, status_s.div_done, in_stall_o, "divider done while idle")
  // a waiting result is never overwritten
  `TPSC_ASSERT_IMP(a_no_overwrite, cmd_s.out_we, !(out_valid_o && out_stall_i), "result overwritten")
  // fraction bit count is one of the three legal values
  `TPSC_ASSERT_IMP(a_frac_legal, out_valid_o, fraction_bits_o == '0 || fraction_bits_o == FRAC_T || fraction_bits_o == FRAC_H, "bad fraction bits")

endmodule

// File: rtl/tpsc_div.sv
// ----------------------------------------------------------------------------
// tpsc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tpsc_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic [DVS_W:0]    rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              borrow;

  assign shifted = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign borrow  = diff[DVS_W+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNT_BITS'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = borrow ? shifted : diff[DVS_W:0];
      quo_d = {quo_q[DVD_W-2:0], ~borrow};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/tpsc_datapath.sv
// ----------------------------------------------------------------------------
// tpsc_datapath
// calibration registers, coefficient storage, shared multiplier and output
// ----------------------------------------------------------------------------
module tpsc_datapath import tpsc_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tpsc_cmd_t             cmd_i,
  output tpsc_status_t          status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  channel_i,
  input  logic                  report_processed_i,
  input  logic [CNT_W-1:0]      raw_sample_i,
  output logic                  channel_out_o,
  output logic [VAL_W-1:0]      value_o,
  output logic [FRAC_W-1:0]     fraction_bits_o,
  output logic                  calib_error_o
);

  localparam int DVD_W = REF_T_W + GAIN_FRACTION_BITS;
  localparam logic [FRAC_W-1:0] FRAC_T = FRAC_W'(GAIN_FRACTION_BITS + TEMP_REF_FRAC_BITS);
  localparam logic [FRAC_W-1:0] FRAC_H = FRAC_W'(GAIN_FRACTION_BITS + HUM_REF_FRAC_BITS);

  // configuration registers
  logic [REF_T_W-1:0] t_ref_lo_q, t_ref_hi_q;
  logic [REF_H_W-1:0] h_ref_lo_q, h_ref_hi_q;
  logic [CNT_W-1:0]   t_cnt_lo_q, t_cnt_hi_q, h_cnt_lo_q, h_cnt_hi_q;

  // coefficients
  logic [VAL_W-1:0] t_gain_q, h_gain_q, t_bias_q, h_bias_q;

  // captured sample
  logic             ch_q, proc_q;
  logic [CNT_W-1:0] raw_q;

  logic [VAL_W-1:0] prod_q;

  logic [VAL_W-1:0]  value_q;
  logic              ch_out_q, err_q;
  logic [FRAC_W-1:0] frac_q;

  // selection for the channel being calibrated
  logic [REF_T_W-1:0] ref0, ref1;
  logic [CNT_W-1:0]   cnt0, cnt1;
  logic [REF_T_W:0]   rdiff;
  logic [REF_T_W-1:0] rmag;
  logic [CNT_W:0]     ddiff;
  logic [CNT_W-1:0]   dmag;
  logic               den_zero, q_neg;
  logic [DVD_W-1:0]   quotient;
  logic               div_done;
  logic [VAL_W-1:0]   q_ext, gain_new, bias_new;

  logic signed [CNT_W-1:0] mul_a;
  logic signed [VAL_W-1:0] mul_g;
  logic signed [VAL_W-1:0] prod_full;
  logic                    mul_ch;

  logic [VAL_W-1:0] ref0_sh, sel_bias, value_new;
  logic             err_new;

  assign status_o.cfg_hit  = cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS));
  assign status_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_ref_lo_q <= '0;
      t_ref_hi_q <= '0;
      t_cnt_lo_q <= '0;
      t_cnt_hi_q <= '0;
      h_ref_lo_q <= '0;
      h_ref_hi_q <= '0;
      h_cnt_lo_q <= '0;
      h_cnt_hi_q <= '0;
      t_gain_q   <= '0;
      h_gain_q   <= '0;
      t_bias_q   <= '0;
      h_bias_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (tpsc_reg_e'(cfg_idx_i))
          REG_TEMP_REF_LOW:    t_ref_lo_q <= cfg_data_i[REF_T_W-1:0];
          REG_TEMP_REF_HIGH:   t_ref_hi_q <= cfg_data_i[REF_T_W-1:0];
          REG_TEMP_COUNT_LOW:  t_cnt_lo_q <= cfg_data_i[CNT_W-1:0];
          REG_TEMP_COUNT_HIGH: t_cnt_hi_q <= cfg_data_i[CNT_W-1:0];
          REG_HUM_REF_LOW:     h_ref_lo_q <= cfg_data_i[REF_H_W-1:0];
          REG_HUM_REF_HIGH:    h_ref_hi_q <= cfg_data_i[REF_H_W-1:0];
          REG_HUM_COUNT_LOW:   h_cnt_lo_q <= cfg_data_i[CNT_W-1:0];
          REG_HUM_COUNT_HIGH:  h_cnt_hi_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.gain_we) begin
        if (cmd_i.cal_ch == CH_HUM) h_gain_q <= gain_new;
        else                        t_gain_q <= gain_new;
      end
      if (cmd_i.bias_we) begin
        if (cmd_i.cal_ch == CH_HUM) h_bias_q <= bias_new;
        else                        t_bias_q <= bias_new;
      end
    end
  end

  // operands of the channel under calibration
  always_comb begin
    if (cmd_i.cal_ch == CH_HUM) begin
      ref0 = {{(REF_T_W-REF_H_W){1'b0}}, h_ref_lo_q};
      ref1 = {{(REF_T_W-REF_H_W){1'b0}}, h_ref_hi_q};
      cnt0 = h_cnt_lo_q;
      cnt1 = h_cnt_hi_q;
    end else begin
      ref0 = t_ref_lo_q;
      ref1 = t_ref_hi_q;
      cnt0 = t_cnt_lo_q;
      cnt1 = t_cnt_hi_q;
    end
  end

  // sign and magnitude split for the unsigned divider
  assign rdiff    = {1'b0, ref1} - {1'b0, ref0};
  assign rmag     = rdiff[REF_T_W] ? REF_T_W'(-rdiff) : rdiff[REF_T_W-1:0];
  assign ddiff    = {cnt1[CNT_W-1], cnt1} - {cnt0[CNT_W-1], cnt0};
  assign dmag     = ddiff[CNT_W] ? CNT_W'(-ddiff) : ddiff[CNT_W-1:0];
  assign den_zero = (ddiff == '0);
  assign q_neg    = rdiff[REF_T_W] ^ ddiff[CNT_W];

  tpsc_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({rmag, {GAIN_FRACTION_BITS{1'b0}}}),
    .divisor_i  (dmag),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign q_ext    = {{(VAL_W-DVD_W){1'b0}}, quotient};
  assign gain_new = den_zero ? '0 : (q_neg ? (~q_ext + 1'b1) : q_ext);

  // shared multiplier: count_low * gain for bias, raw * gain for the value
  // only the low word is kept, so a signed 32-bit product wraps as needed
  assign mul_ch    = cmd_i.mul_bias ? cmd_i.cal_ch : ch_q;
  assign mul_a     = cmd_i.mul_bias ? cnt0 : raw_q;
  assign mul_g     = (mul_ch == CH_HUM) ? h_gain_q : t_gain_q;
  assign prod_full = VAL_W'(mul_a) * mul_g;

  assign ref0_sh  = {{(VAL_W-REF_T_W){1'b0}}, ref0} << GAIN_FRACTION_BITS;
  assign bias_new = ref0_sh - prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ch_q   <= channel_i;
      proc_q <= report_processed_i;
      raw_q  <= raw_sample_i;
    end
    if (cmd_i.mul_we) begin
      prod_q <= prod_full;
    end
    if (cmd_i.out_we) begin
      ch_out_q <= ch_q;
      value_q  <= value_new;
      frac_q   <= proc_q ? ((ch_q == CH_HUM) ? FRAC_H : FRAC_T) : '0;
      err_q    <= err_new;
    end
  end

  assign sel_bias  = (ch_q == CH_HUM) ? h_bias_q : t_bias_q;
  assign value_new = proc_q ? (sel_bias + prod_q) : {{(VAL_W-CNT_W){raw_q[CNT_W-1]}}, raw_q};
  assign err_new   = (ch_q == CH_HUM) ? (h_cnt_lo_q == h_cnt_hi_q) : (t_cnt_lo_q == t_cnt_hi_q);

  assign channel_out_o   = ch_out_q;
  assign value_o         = value_q;
  assign fraction_bits_o = frac_q;
  assign calib_error_o   = err_q;

endmodule

// File: rtl/tpsc_ctrl.sv
// ----------------------------------------------------------------------------
// tpsc_ctrl
// sequencer for recalibration, sample conversion and output handshake
// ----------------------------------------------------------------------------
module tpsc_ctrl import tpsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  tpsc_status_t status_i,
  output tpsc_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_BMUL = 7'b0001000,
    ST_BADD = 7'b0010000,
    ST_VMUL = 7'b0100000,
    ST_VOUT = 7'b1000000
  } tpsc_state_e;

  tpsc_state_e state_q, state_d;
  logic        cal_ch_q, cal_ch_d;
  logic        coef_valid_q, coef_valid_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cal_ch_d     = cal_ch_q;
    coef_valid_d = coef_valid_q;
    cmd_o        = '0;
    cmd_o.cal_ch = cal_ch_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cal_ch_d      = CH_TEMP;
          state_d       = coef_valid_q ? ST_VMUL : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.gain_we = 1'b1;
          state_d       = ST_BMUL;
        end
      end
      ST_BMUL: begin
        cmd_o.mul_bias = 1'b1;
        cmd_o.mul_we   = 1'b1;
        state_d        = ST_BADD;
      end
      ST_BADD: begin
        cmd_o.bias_we = 1'b1;
        if (cal_ch_q == CH_TEMP) begin
          cal_ch_d = CH_HUM;
          state_d  = ST_LOAD;
        end else begin
          coef_valid_d = 1'b1;
          state_d      = ST_VMUL;
        end
      end
      ST_VMUL: begin
        cmd_o.mul_we = 1'b1;
        state_d      = ST_VOUT;
      end
      ST_VOUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_we = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // any register write invalidates the coefficients
    if (status_i.cfg_hit) coef_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_we)                    out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cal_ch_q     <= CH_TEMP;
      coef_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cal_ch_q     <= cal_ch_d;
      coef_valid_q <= coef_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: bench/two_point_sensor_calibration_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_point_sensor_calibration_core_tb
// self-checking bench for the two-point calibration core: a directed opening,
// then randomized calibration phases with random idling on both transfer
// sides; every result is compared field by field with an in-bench prediction
// ----------------------------------------------------------------------------
module two_point_sensor_calibration_core_tb;
  import tpsc_pkg::*;

  localparam int GAIN_FB      = GAIN_FRAC_BITS_DEF;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int MAX_IDLE     = 17;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;

  // kinds of calibration set used by the random phases
  typedef enum int {
    CFG_RANDOM,
    CFG_EXTREME,
    CFG_EQUAL,
    CFG_STEEP
  } cfg_mode_e;

  typedef struct packed {
    logic               ch;
    logic [VAL_W-1:0]   value;
    logic [FRAC_W-1:0]  frac;
    logic               err;
  } calib_result_t;

  // --------------------------------------------------------------------------
  // prediction of the calibration results and the queue of pending results
  // --------------------------------------------------------------------------
  class calib_result_tracker;
    logic [CFG_DATA_W-1:0] regs [NUM_REGS];
    logic [VAL_W-1:0]      gain [2];
    logic [VAL_W-1:0]      bias [2];
    bit                    coeff_valid;
    calib_result_t         pending_results [$];
    int unsigned           mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (gain[i]) begin
        gain[i] = '0;
        bias[i] = '0;
      end
      coeff_valid = 1'b0;
      mismatches  = 0;
    endfunction

    // register write: out-of-range indexes are dropped, wide data is cut
    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic [CFG_DATA_W-1:0] mask;
      if (idx >= NUM_REGS) return;
      case (tpsc_reg_e'(idx))
        REG_TEMP_REF_LOW, REG_TEMP_REF_HIGH: mask = CFG_DATA_W'((1 << REF_T_W) - 1);
        REG_HUM_REF_LOW, REG_HUM_REF_HIGH:   mask = CFG_DATA_W'((1 << REF_H_W) - 1);
        default:                             mask = '1;
      endcase
      regs[idx]   = data & mask;
      coeff_valid = 1'b0;
    endfunction

    // gain truncates toward zero; equal counts give gain 0
    function void derive(int c, logic [CFG_DATA_W-1:0] r0, logic [CFG_DATA_W-1:0] r1,
                         logic [CFG_DATA_W-1:0] c0, logic [CFG_DATA_W-1:0] c1);
      longint cnt0;
      longint den;
      longint num;
      longint quo;
      cnt0 = longint'($signed(c0));
      den  = longint'($signed(c1)) - cnt0;
      num  = (longint'(r1) - longint'(r0)) * (longint'(1) << GAIN_FB);
      quo  = (den != 0) ? num / den : 0;
      gain[c] = quo[VAL_W-1:0];
      bias[c] = (VAL_W'(r0) << GAIN_FB) - VAL_W'(cnt0) * gain[c];
    endfunction

    // accepted sample: recalibrate if needed, then queue the expected result
    function void take_sample(logic ch, logic proc, logic [CNT_W-1:0] raw);
      logic signed [VAL_W-1:0] raw_ext;
      calib_result_t           res;
      if (!coeff_valid) begin
        derive(CH_TEMP, regs[REG_TEMP_REF_LOW], regs[REG_TEMP_REF_HIGH],
               regs[REG_TEMP_COUNT_LOW], regs[REG_TEMP_COUNT_HIGH]);
        derive(CH_HUM, regs[REG_HUM_REF_LOW], regs[REG_HUM_REF_HIGH],
               regs[REG_HUM_COUNT_LOW], regs[REG_HUM_COUNT_HIGH]);
        coeff_valid = 1'b1;
      end
      raw_ext = VAL_W'($signed(raw));
      res.ch  = ch;
      if (ch == CH_TEMP) begin
        res.err  = regs[REG_TEMP_COUNT_LOW] == regs[REG_TEMP_COUNT_HIGH];
        res.frac = FRAC_W'(GAIN_FB + TEMP_REF_FRAC_BITS);
      end else begin
        res.err  = regs[REG_HUM_COUNT_LOW] == regs[REG_HUM_COUNT_HIGH];
        res.frac = FRAC_W'(GAIN_FB + HUM_REF_FRAC_BITS);
      end
      if (proc) begin
        res.value = bias[ch] + raw_ext * gain[ch];
      end else begin
        res.value = raw_ext;
        res.frac  = '0;
      end
      pending_results.push_back(res);
    endfunction

    function void compare_result(calib_result_t got);
      calib_result_t exp_res;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result with none pending: ch=%0d value=%h frac=%0d err=%0d",
                   got.ch, got.value, got.frac, got.err);
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.ch !== exp_res.ch || got.value !== exp_res.value ||
          got.frac !== exp_res.frac || got.err !== exp_res.err) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch exp ch=%0d %h f=%0d e=%0d got ch=%0d %h f=%0d e=%0d",
                   exp_res.ch, exp_res.value, exp_res.frac, exp_res.err,
                   got.ch, got.value, got.frac, got.err);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block ports, every input known from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni             = 1'b0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_stall_o;
  logic                  channel_i          = CH_TEMP;
  logic                  report_processed_i = 1'b0;
  logic [CNT_W-1:0]      raw_sample_i       = '0;
  logic                  out_valid_o;
  logic                  out_stall_i        = 1'b1;
  logic                  channel_out_o;
  logic [VAL_W-1:0]      value_o;
  logic [FRAC_W-1:0]     fraction_bits_o;
  logic                  calib_error_o;
  logic                  cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i          = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i         = '0;

  // idling switches for the sender and the receiver, set by the stimulus
  bit tx_gaps_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  bit long_hold_req = 1'b0;

  int unsigned cycle_count = 0;

  calib_result_tracker tracker = new();

  two_point_sensor_calibration_core #(
    .GAIN_FRACTION_BITS (GAIN_FB)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .channel_i          (channel_i),
    .report_processed_i (report_processed_i),
    .raw_sample_i       (raw_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .channel_out_o      (channel_out_o),
    .value_o            (value_o),
    .fraction_bits_o    (fraction_bits_o),
    .calib_error_o      (calib_error_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------

  // one register write; the caller drops the write enable after a batch
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.load_reg(idx, data);
  endtask

  // one sample transfer; valid stays high so a gap-free next sample follows
  task automatic send_sample(input logic ch, input logic proc,
                             input logic [CNT_W-1:0] raw);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(MAX_IDLE, 0) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    channel_i          <= ch;
    report_processed_i <= proc;
    raw_sample_i       <= raw;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_sample(ch, proc, raw);
  endtask

  // every sample yields a result, so an empty queue means the core is idle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // count draw biased toward the edges of the signed range
  function automatic logic [CFG_DATA_W-1:0] pick_count(bit edges_only);
    case ($urandom_range(edges_only ? 1 : 5, 0))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stalls per transfer, plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned   hold;
    calib_result_t got;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        // stall long enough for the core to back up into its input
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      hold = rx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.ch    = channel_out_o;
      got.value = value_o;
      got.frac  = fraction_bits_o;
      got.err   = calib_error_o;
      tracker.compare_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] vals [NUM_REGS];
    cfg_mode_e             mode;
    logic                  ch;
    logic                  proc;
    logic [CNT_W-1:0]      raw;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: all counts equal, so both channels flag an error
    send_sample(CH_TEMP, 1'b0, 16'h7FFF);
    send_sample(CH_TEMP, 1'b1, 16'h8000);
    send_sample(CH_HUM,  1'b1, 16'h1234);
    send_sample(CH_HUM,  1'b0, 16'h8000);
    wait_idle();

    // full-range temperature span; oversized ref data gets cut to width;
    // humidity counts equal but nonzero
    cfg_write(REG_TEMP_REF_LOW,    16'd200);
    cfg_write(REG_TEMP_REF_HIGH,   16'hFFFF);
    cfg_write(REG_TEMP_COUNT_LOW,  16'h8000);
    cfg_write(REG_TEMP_COUNT_HIGH, 16'h7FFF);
    cfg_write(REG_HUM_REF_LOW,     16'h01F0);
    cfg_write(REG_HUM_REF_HIGH,    16'd20);
    cfg_write(REG_HUM_COUNT_LOW,   16'd1000);
    cfg_write(REG_HUM_COUNT_HIGH,  16'd1000);
    // index past the register file is ignored
    cfg_write(CFG_IDX_W'(NUM_REGS), 16'hFFFF);
    cfg_we_i <= 1'b0;
    send_sample(CH_TEMP, 1'b1, 16'h8000);
    send_sample(CH_TEMP, 1'b1, 16'h7FFF);
    send_sample(CH_TEMP, 1'b1, 16'h0000);
    send_sample(CH_TEMP, 1'b0, 16'h0005);
    send_sample(CH_HUM,  1'b1, 16'd1000);
    send_sample(CH_HUM,  1'b1, 16'hFFFF);
    send_sample(CH_HUM,  1'b0, 16'h7FFF);
    wait_idle();

    // count difference of one gives the steepest gain and wraps the value;
    // humidity falls, so the gain is negative and truncates toward zero
    cfg_write(REG_TEMP_REF_LOW,    16'd0);
    cfg_write(REG_TEMP_REF_HIGH,   16'd1023);
    cfg_write(REG_TEMP_COUNT_LOW,  16'h7FFE);
    cfg_write(REG_TEMP_COUNT_HIGH, 16'h7FFF);
    cfg_write(REG_HUM_REF_LOW,     16'd255);
    cfg_write(REG_HUM_REF_HIGH,    16'd0);
    cfg_write(REG_HUM_COUNT_LOW,   16'hFFFB);
    cfg_write(REG_HUM_COUNT_HIGH,  16'd2);
    cfg_we_i <= 1'b0;
    send_sample(CH_TEMP, 1'b1, 16'h8000);
    send_sample(CH_TEMP, 1'b1, 16'h7FFF);
    send_sample(CH_HUM,  1'b1, 16'h8000);
    send_sample(CH_HUM,  1'b1, 16'h7FFF);
    send_sample(CH_HUM,  1'b1, 16'h0000);
    send_sample(CH_TEMP, 1'b0, 16'h8000);
    wait_idle();

    // a single write must also force a recalibration
    cfg_write(REG_HUM_COUNT_HIGH, 16'd9);
    cfg_we_i <= 1'b0;
    send_sample(CH_HUM,  1'b1, 16'h0100);
    send_sample(CH_TEMP, 1'b1, 16'h0100);

    // random phases, each with a fresh calibration set
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      mode = cfg_mode_e'($urandom_range(CFG_STEEP, CFG_RANDOM));
      for (int r = 0; r < NUM_REGS; r++) begin
        case (tpsc_reg_e'(r))
          REG_TEMP_REF_LOW, REG_TEMP_REF_HIGH, REG_HUM_REF_LOW, REG_HUM_REF_HIGH:
            if (mode == CFG_RANDOM) vals[r] = CFG_DATA_W'($urandom);
            else vals[r] = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
          default:
            vals[r] = pick_count(mode == CFG_EXTREME);
        endcase
      end
      if (mode == CFG_EQUAL) begin
        if ($urandom_range(1, 0)) vals[REG_TEMP_COUNT_HIGH] = vals[REG_TEMP_COUNT_LOW];
        else vals[REG_HUM_COUNT_HIGH] = vals[REG_HUM_COUNT_LOW];
      end else if (mode == CFG_STEEP) begin
        vals[REG_TEMP_COUNT_HIGH] = vals[REG_TEMP_COUNT_LOW] + 1'b1;
        vals[REG_HUM_COUNT_HIGH]  = vals[REG_HUM_COUNT_LOW] - 1'b1;
      end
      for (int r = 0; r < NUM_REGS; r++) cfg_write(tpsc_reg_e'(r), vals[r]);
      if ($urandom_range(1, 0))
        cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_REGS)),
                  CFG_DATA_W'($urandom));
      cfg_we_i <= 1'b0;

      // idling pattern of this phase; one phase backs the core up
      tx_gaps_on = (ph % 3) != 1;
      rx_idle_on = (ph % 4) != 2;
      if (ph == 4) begin
        tx_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && (ph % 2) == 1) begin
          // touch one register mid-phase
          wait_idle();
          cfg_write(tpsc_reg_e'($urandom_range(NUM_REGS - 1, 0)), CFG_DATA_W'($urandom));
          cfg_we_i <= 1'b0;
        end
        ch   = $urandom_range(1, 0);
        proc = $urandom_range(3, 0) != 0;
        case ($urandom_range(7, 0))
          0:       raw = 16'h8000;
          1:       raw = 16'h7FFF;
          2:       raw = 16'h0000;
          3:       raw = tracker.regs[ch ? REG_HUM_COUNT_LOW : REG_TEMP_COUNT_LOW];
          4:       raw = tracker.regs[ch ? REG_HUM_COUNT_HIGH : REG_TEMP_COUNT_HIGH];
          default: raw = CNT_W'($urandom);
        endcase
        send_sample(ch, proc, raw);
      end
    end

    // drain, then allow for any stray result
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    tracker.mismatches += tracker.pending_results.size();
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
